>>> design/japs_pkg.sv
// Package for the JPEG APPn segment stripper: field widths, marker codes,
// phase encoding and the record types shared by the step logic and the top level.
// No dependencies.
package japs_pkg;

   localparam int COUNT_WIDTH = 24;
   localparam int MAX_RSP     = 3;
   localparam int RSP_CNT_W   = $clog2(MAX_RSP + 1);

   localparam logic [7:0] MARK_PREFIX  = 8'hFF;
   localparam logic [7:0] APP_FIRST    = 8'hE1;
   localparam logic [7:0] APP_LAST     = 8'hEF;
   localparam logic [15:0] LEN_MIN     = 16'd2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   typedef enum logic [2:0] {
      PH_NORMAL   = 3'd0,
      PH_HOLD_FF  = 3'd1,
      PH_MARKER   = 3'd2,
      PH_LEN_HIGH = 3'd3,
      PH_SKIP     = 3'd4
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [7:0]             held_marker;
      logic [7:0]             held_len_high;
      logic [15:0]            skip_left;
      logic [COUNT_WIDTH-1:0] byte_count;
   } state_type;

   typedef struct packed {
      logic [7:0]             out_byte;
      logic                   byte_valid;
      logic                   frame_end;
      logic [COUNT_WIDTH-1:0] kept_count;
   } rsp_type;

   typedef rsp_type [MAX_RSP-1:0] rsp_set_type;

endpackage

>>> design/japs_if.sv
// Valid/ready channel interfaces for the stripper's byte input and result output.
// Depends on japs_pkg.
interface japs_req_if;
   import japs_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       is_last;

   modport source (output valid, output in_byte, output is_last, input ready);
   modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface japs_rsp_if;
   import japs_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [7:0]             out_byte;
   logic                   byte_valid;
   logic                   frame_end;
   logic [COUNT_WIDTH-1:0] kept_count;

   modport source (output valid, output out_byte, output byte_valid, output frame_end,
                   output kept_count, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input frame_end,
                   input kept_count, output ready);
endinterface

>>> design/japs_step.sv
// Per-byte step of the stripper: next state and up to three result words.
// Depends on japs_pkg.
module japs_step (
   input  japs_pkg::state_type   state,
   input  logic [7:0]            in_byte,
   input  logic                  is_last,
   output japs_pkg::state_type   state_next,
   output japs_pkg::rsp_set_type results,
   output logic [japs_pkg::RSP_CNT_W-1:0] num_results
);
   import japs_pkg::*;

   logic                   is_app;
   logic [15:0]            seg_len;
   logic [7:0]             e_byte  [MAX_RSP];
   logic                   e_valid [MAX_RSP];
   logic                   e_end   [MAX_RSP];
   logic [COUNT_WIDTH-1:0] run_count;
   state_type              upd;

   assign is_app  = in_byte inside {[APP_FIRST:APP_LAST]};
   assign seg_len = {state.held_len_high, in_byte};

   always_comb begin
      upd         = state;
      num_results = '0;
      for (int k = 0; k < MAX_RSP; k++) begin
         e_byte[k]  = '0;
         e_valid[k] = 1'b0;
         e_end[k]   = 1'b0;
      end

      case (state.phase)
         PH_HOLD_FF: begin
            e_byte[0]  = MARK_PREFIX;
            e_valid[0] = 1'b1;
            if (is_app) begin
               if (is_last) begin
                  e_byte[1]   = in_byte;
                  e_valid[1]  = 1'b1;
                  e_end[1]    = 1'b1;
                  num_results = RSP_CNT_W'(2);
               end else begin
                  e_valid[0]      = 1'b0;
                  e_byte[0]       = '0;
                  upd.held_marker = in_byte;
                  upd.phase       = PH_MARKER;
               end
            end else if (in_byte == MARK_PREFIX && !is_last) begin
               num_results = RSP_CNT_W'(1);
               upd.phase   = PH_HOLD_FF;
            end else begin
               e_byte[1]   = in_byte;
               e_valid[1]  = 1'b1;
               e_end[1]    = is_last;
               num_results = RSP_CNT_W'(2);
               upd.phase   = PH_NORMAL;
            end
         end
         PH_MARKER: begin
            if (is_last) begin
               e_byte[0]   = MARK_PREFIX;
               e_valid[0]  = 1'b1;
               e_byte[1]   = state.held_marker;
               e_valid[1]  = 1'b1;
               e_byte[2]   = in_byte;
               e_valid[2]  = 1'b1;
               e_end[2]    = 1'b1;
               num_results = RSP_CNT_W'(3);
            end else begin
               upd.held_len_high = in_byte;
               upd.phase         = PH_LEN_HIGH;
            end
         end
         PH_LEN_HIGH: begin
            // short lengths mean an empty body
            upd.skip_left = (seg_len < LEN_MIN) ? '0 : seg_len - LEN_MIN;
            upd.phase     = (upd.skip_left != '0) ? PH_SKIP : PH_NORMAL;
            if (is_last) begin
               e_end[0]    = 1'b1;
               num_results = RSP_CNT_W'(1);
            end
         end
         PH_SKIP: begin
            if (state.skip_left != '0)
               upd.skip_left = state.skip_left - 16'd1;
            if (upd.skip_left == '0)
               upd.phase = PH_NORMAL;
            if (is_last) begin
               e_end[0]    = 1'b1;
               num_results = RSP_CNT_W'(1);
            end
         end
         default: begin
            if (in_byte == MARK_PREFIX && !is_last) begin
               upd.phase = PH_HOLD_FF;
            end else begin
               e_byte[0]   = in_byte;
               e_valid[0]  = 1'b1;
               e_end[0]    = is_last;
               num_results = RSP_CNT_W'(1);
               upd.phase   = PH_NORMAL;
            end
         end
      endcase

      // running kept count, saturating, after each result word
      run_count = state.byte_count;
      for (int k = 0; k < MAX_RSP; k++) begin
         if (e_valid[k] && run_count != COUNT_MAX)
            run_count = run_count + COUNT_WIDTH'(1);
         results[k].out_byte   = e_byte[k];
         results[k].byte_valid = e_valid[k];
         results[k].frame_end  = e_end[k];
         results[k].kept_count = run_count;
      end
      upd.byte_count = run_count;

      if (is_last) begin
         state_next       = '0;
         state_next.phase = PH_NORMAL;
      end else begin
         state_next = upd;
      end
   end

endmodule

>>> design/jpeg_app_segment_stripper.sv
// Top level of the JPEG APPn segment stripper: state register, step logic and
// a three-word result buffer. Depends on japs_pkg, japs_if.sv and japs_step.
//
//   channel | dir | words                               | handshake
//   --------+-----+-------------------------------------+-------------
//   req_    | in  | in_byte, is_last                    | valid/ready
//   rsp_    | out | out_byte, byte_valid, frame_end,    | valid/ready
//           |     | kept_count                          |
//
// One byte is taken per cycle whenever each byte yields at most one word and
// the rsp_ side is ready. A byte that yields two or three words (a partial marker
// header at frame end, or a 0xFF that turns out not to open a segment) holds off
// the next byte until the buffer drains, one word a cycle while rsp_ is ready.
// Synchronous active-high reset returns the phase to normal copy and empties
// the buffer. A stalled rsp_ side holds the buffer; req_ready stays high
// while the last buffered word leaves in the same cycle.
module jpeg_app_segment_stripper (
   input logic      clock,
   input logic      reset,
   japs_req_if.sink   req_chan,
   japs_rsp_if.source rsp_chan
);
   import japs_pkg::*;

   state_type              state_ff;
   state_type              state_in;
   state_type              step_state;
   rsp_set_type            step_results;
   logic [RSP_CNT_W-1:0]   step_num;

   rsp_set_type            slots_ff;
   rsp_set_type            slots_in;
   logic [RSP_CNT_W-1:0]   cnt_ff;
   logic [RSP_CNT_W-1:0]   cnt_in;
   logic [RSP_CNT_W-1:0]   cnt_after;

   logic                   pop;
   logic                   push;

   japs_step u_step (
      .state       (state_ff),
      .in_byte     (req_chan.in_byte),
      .is_last     (req_chan.is_last),
      .state_next  (step_state),
      .results     (step_results),
      .num_results (step_num)
   );

   // take a byte only when the buffer is empty after this cycle's pop
   assign pop       = (cnt_ff != '0) && rsp_chan.ready;
   assign cnt_after = cnt_ff - RSP_CNT_W'(pop);
   assign req_chan.ready = (cnt_after == '0);
   assign push      = req_chan.valid && req_chan.ready;

   always_comb begin
      slots_in = slots_ff;
      cnt_in   = cnt_after;
      state_in = state_ff;
      // advance the buffer toward the head
      if (pop) begin
         for (int k = 0; k < MAX_RSP - 1; k++)
            slots_in[k] = slots_ff[k+1];
      end
      if (push) begin
         slots_in = step_results;
         cnt_in   = step_num;
         state_in = step_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_NORMAL, default: '0};
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // result words carry no reset
   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   assign rsp_chan.valid      = (cnt_ff != '0);
   assign rsp_chan.out_byte   = slots_ff[0].out_byte;
   assign rsp_chan.byte_valid = slots_ff[0].byte_valid;
   assign rsp_chan.frame_end  = slots_ff[0].frame_end;
   assign rsp_chan.kept_count = slots_ff[0].kept_count;

endmodule

>>> test/tb.sv
// Testbench for jpeg_app_segment_stripper: directed and random JPEG frames,
// with its own predictor, bursty byte input and a stalling result side.
// Depends on japs_pkg, japs_if.sv and the stripper RTL.
`timescale 1ns / 100ps

module tb;
   import japs_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_BYTES  = 460;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_last;
   } frame_byte_type;

   // Result side stall patterns
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_PERIODIC,
      RX_MOSTLY
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   japs_req_if req_chan ();
   japs_rsp_if rsp_chan ();

   jpeg_app_segment_stripper i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Bytes waiting to be sent, and the frame being assembled
   frame_byte_type stream_q[$];
   logic [7:0]     frame_buf[$];

   // Kept-byte words the stripper still owes us
   rsp_type kept_words_q[$];

   int mismatch_count;
   int cycle_count;

   // ---------------------------------------------------------------
   // Predictor state: mirror of the stripper's per-frame state
   // ---------------------------------------------------------------
   phase_type              strip_phase;
   logic [7:0]             held_marker;
   logic [7:0]             held_len_high;
   logic [15:0]            skip_left;
   logic [COUNT_WIDTH-1:0] kept_count;

   function automatic void clear_strip_state();
      strip_phase   = PH_NORMAL;
      held_marker   = 8'h00;
      held_len_high = 8'h00;
      skip_left     = 16'h0000;
      kept_count    = '0;
   endfunction

   // Queue one expected result word; the count includes this word's byte.
   function automatic void emit_word(logic [7:0] b, logic valid, logic last);
      rsp_type w;
      if (valid && kept_count != COUNT_MAX)
         kept_count = kept_count + 1'b1;
      w.out_byte   = valid ? b : 8'h00;
      w.byte_valid = valid;
      w.frame_end  = last;
      w.kept_count = kept_count;
      kept_words_q.push_back(w);
   endfunction

   // Advance the predictor by one input byte.
   function automatic void strip_byte(logic [7:0] b, logic last);
      logic        is_app;
      logic [15:0] seg_len;
      is_app = (b >= APP_FIRST) && (b <= APP_LAST);
      case (strip_phase)
         PH_HOLD_FF: begin
            if (is_app) begin
               if (last) begin
                  emit_word(MARK_PREFIX, 1'b1, 1'b0);
                  emit_word(b, 1'b1, 1'b1);
               end else begin
                  held_marker = b;
                  strip_phase = PH_MARKER;
               end
            end else begin
               // Held 0xFF opened nothing: keep it, then look at b afresh
               emit_word(MARK_PREFIX, 1'b1, 1'b0);
               if (b == MARK_PREFIX && !last) begin
                  strip_phase = PH_HOLD_FF;
               end else begin
                  emit_word(b, 1'b1, last);
                  strip_phase = PH_NORMAL;
               end
            end
         end
         PH_MARKER: begin
            if (last) begin
               emit_word(MARK_PREFIX, 1'b1, 1'b0);
               emit_word(held_marker, 1'b1, 1'b0);
               emit_word(b, 1'b1, 1'b1);
            end else begin
               held_len_high = b;
               strip_phase   = PH_LEN_HIGH;
            end
         end
         PH_LEN_HIGH: begin
            seg_len = {held_len_high, b};
            if (seg_len < LEN_MIN)
               seg_len = LEN_MIN;
            skip_left = seg_len - LEN_MIN;
            if (skip_left != 0)
               strip_phase = PH_SKIP;
            else
               strip_phase = PH_NORMAL;
            if (last)
               emit_word(8'h00, 1'b0, 1'b1);
         end
         PH_SKIP: begin
            if (skip_left != 0)
               skip_left = skip_left - 1'b1;
            if (skip_left == 0)
               strip_phase = PH_NORMAL;
            if (last)
               emit_word(8'h00, 1'b0, 1'b1);
         end
         default: begin
            if (b == MARK_PREFIX && !last) begin
               strip_phase = PH_HOLD_FF;
            end else begin
               emit_word(b, 1'b1, last);
               strip_phase = PH_NORMAL;
            end
         end
      endcase
      if (last)
         clear_strip_state();
   endfunction

   // ---------------------------------------------------------------
   // Frame building
   // ---------------------------------------------------------------

   // Move the assembled frame to the send queue, flagging its final byte.
   function automatic void flush_frame();
      frame_byte_type fb;
      for (int i = 0; i < frame_buf.size(); i++) begin
         fb.in_byte = frame_buf[i];
         fb.is_last = (i == frame_buf.size() - 1);
         stream_q.push_back(fb);
      end
      frame_buf.delete();
   endfunction

   // Append one APPn segment with random content; mostly well formed.
   function automatic void add_app_segment();
      logic [15:0] seg_len;
      int          body;
      int          pick;
      frame_buf.push_back(MARK_PREFIX);
      frame_buf.push_back(8'($urandom_range(APP_FIRST, APP_LAST)));
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         seg_len = 16'($urandom_range(0, 1));
         body    = 0;
      end else if (pick == 1) begin
         // Arbitrary length: the frame most likely ends inside the body
         seg_len = 16'($urandom);
         body    = $urandom_range(0, 10);
      end else begin
         seg_len = 16'($urandom_range(2, 14));
         body    = seg_len - 2;
      end
      frame_buf.push_back(seg_len[15:8]);
      frame_buf.push_back(seg_len[7:0]);
      repeat (body) frame_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Build one random frame, cut short now and then.
   function automatic void add_random_frame();
      int parts;
      int kind;
      int cut;
      parts = $urandom_range(1, 6);
      for (int p = 0; p < parts; p++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            // Plain entropy-coded run, with the odd 0xFF before a random byte
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 15) == 0)
                  frame_buf.push_back(MARK_PREFIX);
               frame_buf.push_back(8'($urandom_range(0, 255)));
            end
         end else if (kind < 8) begin
            add_app_segment();
         end else if (kind == 8) begin
            // Noise biased toward marker-like bytes
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 2))
                  0: frame_buf.push_back(MARK_PREFIX);
                  1: frame_buf.push_back(8'($urandom_range(APP_FIRST - 1, APP_LAST + 1)));
                  default: frame_buf.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end else begin
            repeat ($urandom_range(1, 3)) frame_buf.push_back(MARK_PREFIX);
         end
      end
      if (frame_buf.size() > 1 && $urandom_range(0, 3) == 0) begin
         cut = $urandom_range(1, frame_buf.size());
         while (frame_buf.size() > cut)
            void'(frame_buf.pop_back());
      end
      flush_frame();
   endfunction

   // ---------------------------------------------------------------
   // Driver: send bytes in bursts of random length with random gaps
   // ---------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      logic accepted;
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.in_byte <= 8'h00;
         req_chan.is_last <= 1'b0;
         burst_left = $urandom_range(1, 16);
         gap_left   = 0;
      end else begin
         accepted = req_chan.valid && req_chan.ready;
         if (accepted) begin
            void'(stream_q.pop_front());
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               // Zero gap now and then gives long stretches at full rate
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end
         // Hold the word while the stripper is not taking it
         if (!(req_chan.valid && !accepted)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (stream_q.size() > 0) begin
               req_chan.valid   <= 1'b1;
               req_chan.in_byte <= stream_q[0].in_byte;
               req_chan.is_last <= stream_q[0].is_last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Receiver: stall on patterns that change every so often
   // ---------------------------------------------------------------
   rx_mode_type rx_mode;
   int          rx_mode_left;
   int          rx_tick;

   always @(posedge clock) begin
      logic rdy;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_mode_left = 0;
         rx_tick      = 0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(32, 200);
         end
         rx_mode_left--;
         rx_tick++;
         case (rx_mode)
            RX_OPEN:     rdy = 1'b1;
            RX_COIN:     rdy = $urandom_range(0, 1) == 1;
            RX_PERIODIC: rdy = (rx_tick % 4) == 0;
            default:     rdy = $urandom_range(0, 4) != 0;
         endcase
         rsp_chan.ready <= rdy;
      end
   end

   // ---------------------------------------------------------------
   // Monitor: predict on each accepted byte, then check each result word.
   // A byte's result words appear only after it is accepted, so its prediction is queued first.
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         clear_strip_state();
      end else begin
         if (req_chan.valid && req_chan.ready)
            strip_byte(req_chan.in_byte, req_chan.is_last);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.out_byte   = rsp_chan.out_byte;
            got.byte_valid = rsp_chan.byte_valid;
            got.frame_end  = rsp_chan.frame_end;
            got.kept_count = rsp_chan.kept_count;
            if (kept_words_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected word: byte %h valid %b end %b count %0d",
                           got.out_byte, got.byte_valid, got.frame_end, got.kept_count);
            end else begin
               want = kept_words_q.pop_front();
               if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
                   got.frame_end !== want.frame_end || got.kept_count !== want.kept_count)
               begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch: expected %h/%b/%b/%0d, got %h/%b/%b/%0d",
                              want.out_byte, want.byte_valid, want.frame_end,
                              want.kept_count, got.out_byte, got.byte_valid,
                              got.frame_end, got.kept_count);
               end
            end
         end
      end
   end

   // Drop the run if it hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------
   initial begin
      int directed_bytes;
      reset = 1'b1;

      // Single-byte frames: lowest byte, and a lone 0xFF at the end
      frame_buf = '{8'h00};
      flush_frame();
      frame_buf = '{8'hFF};
      flush_frame();
      // Partial headers at frame end: marker only, then marker and length high
      frame_buf = '{8'hFF, 8'hE1};
      flush_frame();
      frame_buf = '{8'hFF, 8'hEF, 8'h12};
      flush_frame();
      // Two 0xFF at the end, both kept
      frame_buf = '{8'hFF, 8'hFF};
      flush_frame();
      // Markers just outside the APPn range, 0xFF run before APPn, short lengths
      frame_buf = '{8'hFF, 8'hE0, 8'hFF, 8'hF0, 8'hFF, 8'hFF, 8'hE1, 8'h00, 8'h00,
                    8'hFF, 8'hE5, 8'h00, 8'h01, 8'h80};
      flush_frame();
      // Frame ends on the low length byte, and inside a long segment
      frame_buf = '{8'hFF, 8'hE2, 8'h00, 8'h04};
      flush_frame();
      frame_buf = '{8'hFF, 8'hE3, 8'hFF, 8'hFF, 8'hAB};
      flush_frame();
      // Frame ends exactly on the last body byte
      frame_buf = '{8'h7F, 8'hFF, 8'hE8, 8'h00, 8'h03, 8'h44};
      flush_frame();
      directed_bytes = stream_q.size();

      while (stream_q.size() < directed_bytes + RANDOM_BYTES)
         add_random_frame();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Let every byte go out, then every owed word come back
      while (stream_q.size() > 0 || req_chan.valid)
         @(posedge clock);
      while (kept_words_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && kept_words_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
design/japs_pkg.sv
design/japs_if.sv
design/japs_step.sv
design/jpeg_app_segment_stripper.sv
test/tb.sv
